/* rtl/bbs_pkg.sv */
package bbs_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 10;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int CCMP_W  = (COL_W > DIM_W) ? COL_W : DIM_W;
    localparam int RCMP_W  = (ROW_W > DIM_W) ? ROW_W : DIM_W;
    localparam int LINE_W  = 2 * PIX_W;
    localparam int SUM3_W  = PIX_W + 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 10'd400;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 10'd296;
    localparam logic [DIM_W-1:0] DIM_MIN          = 10'd2;

    // x/3 as (x*683) >> 11, exact for x < 768
    localparam logic [SUM3_W-1:0] RECIP3    = 10'd683;
    localparam int                RECIP3_SH = 11;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] blurred;
        logic             eol;
        logic             eof;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic             flush;
        logic             emit;
        logic             row_is_second;
        logic             eol;
        logic             eof;
        logic             fwd;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] hmean;
    } t_feed;

    function automatic logic [PIX_W-1:0] div3(input logic [SUM3_W-1:0] x);
        logic [2*SUM3_W-1:0] p;
        p = (2*SUM3_W)'(x) * (2*SUM3_W)'(RECIP3);
        return p[RECIP3_SH +: PIX_W];
    endfunction

    function automatic logic [PIX_W-1:0] half2(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PIX_W:1];
    endfunction

    function automatic logic [SUM3_W-1:0] sum3(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b,
                                               input logic [PIX_W-1:0] c);
        return SUM3_W'(a) + SUM3_W'(b) + SUM3_W'(c);
    endfunction

endpackage

/* rtl/bbs_stream_if.sv */
interface bbs_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [bbs_pkg::PIX_W-1:0]   pixel;

    modport source (output valid, output op, output pixel, input ready);
    modport sink   (input valid, input op, input pixel, output ready);
endinterface

interface bbs_out_if;
    logic                        valid;
    logic                        ready;
    logic [bbs_pkg::PIX_W-1:0]   blurred;
    logic                        end_of_line;
    logic                        end_of_frame;

    modport source (output valid, output blurred, output end_of_line,
                    output end_of_frame, input ready);
    modport sink   (input valid, input blurred, input end_of_line,
                    input end_of_frame, output ready);
endinterface

/* rtl/bbs_line_ram.sv */
module bbs_line_ram (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [bbs_pkg::COL_W-1:0]     i_waddr,
    input  logic [bbs_pkg::LINE_W-1:0]    i_wdata,
    input  logic [bbs_pkg::COL_W-1:0]     i_raddr,
    output logic [bbs_pkg::LINE_W-1:0]    o_rdata
);

    logic [bbs_pkg::LINE_W-1:0] r_mem [bbs_pkg::MAX_WIDTH];
    logic [bbs_pkg::LINE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bbs_result_fifo.sv */
module bbs_result_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  bbs_pkg::t_result             i_data,
    output logic [bbs_pkg::FIFO_AW:0]    o_count,
    bbs_out_if.source                    o_res
);

    bbs_pkg::t_result              r_mem [bbs_pkg::FIFO_DEPTH];
    logic [bbs_pkg::FIFO_AW-1:0]   r_wr_ptr;
    logic [bbs_pkg::FIFO_AW-1:0]   r_rd_ptr;
    logic [bbs_pkg::FIFO_AW:0]     r_count;
    logic [bbs_pkg::FIFO_AW:0]     n_count;
    logic                          pop;
    bbs_pkg::t_result              head;

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_mem[r_rd_ptr];

    assign o_res.valid        = (r_count != '0);
    assign o_res.blurred      = head.blurred;
    assign o_res.end_of_line  = head.eol;
    assign o_res.end_of_frame = head.eof;
    assign o_count            = r_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

/* rtl/box_blur_3x3_separable.sv */
// Separable 3x3 box blur, 8-bit grey, raster order.
// A result word is registered in r_s1, then queued in the fifo that drives o_res.
// Throughput: one word per cycle when the fifo has room; a last-column pixel holds
// i_pix.ready low as its second line-end result takes the line store read/write port.
// Reset: counters and pipeline cleared, widths 400 x 296; line store left unset.
module box_blur_3x3_separable (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bbs_in_if.sink                            i_pix,
    bbs_out_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [bbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bbs_pkg::DIM_W-1:0]         i_cfg_data
);

    logic [bbs_pkg::DIM_W-1:0]   r_frame_width;
    logic [bbs_pkg::DIM_W-1:0]   r_frame_height;
    logic [bbs_pkg::PIX_W-1:0]   r_px_older;
    logic [bbs_pkg::PIX_W-1:0]   r_px_newer;
    logic [bbs_pkg::COL_W-1:0]   r_in_col;
    logic [bbs_pkg::ROW_W-1:0]   r_in_row;
    logic [bbs_pkg::COL_W-1:0]   r_out_col;

    logic                        r_pend;
    logic [bbs_pkg::COL_W-1:0]   r_pend_col;
    logic [bbs_pkg::PIX_W-1:0]   r_pend_hm;
    logic                        r_pend_emit;
    logic                        r_pend_is2;

    bbs_pkg::t_feed              r_s1;
    bbs_pkg::t_feed              n_s1;
    logic [bbs_pkg::LINE_W-1:0]  r_fwd_line;

    logic [bbs_pkg::DIM_W-1:0]   w_used;
    logic [bbs_pkg::DIM_W-1:0]   h_used;
    logic [bbs_pkg::DIM_W-1:0]   w_m1;
    logic [bbs_pkg::DIM_W-1:0]   h_m1;
    logic                        col_last;
    logic                        row_last;
    logic                        out_last;
    logic                        row_ge1;
    logic                        row_is1;
    logic [bbs_pkg::COL_W-1:0]   col_prev;
    logic [bbs_pkg::PIX_W-1:0]   hm_main;
    logic [bbs_pkg::PIX_W-1:0]   hm_edge;

    logic [bbs_pkg::FIFO_AW:0]   fifo_count;
    logic [bbs_pkg::FIFO_AW+1:0] occupancy;
    logic                        credit_ok;
    logic                        in_acc;
    logic                        is_flush;
    logic                        cfg_hit;

    logic [bbs_pkg::LINE_W-1:0]  ram_q;
    logic [bbs_pkg::LINE_W-1:0]  line;
    logic [bbs_pkg::PIX_W-1:0]   two;
    logic [bbs_pkg::PIX_W-1:0]   one;
    logic [bbs_pkg::LINE_W-1:0]  wr_line;
    logic                        ram_we;
    bbs_pkg::t_result            res;
    logic                        res_push;

    // clamped frame size
    always_comb begin
        if (r_frame_width < bbs_pkg::DIM_MIN) begin
            w_used = bbs_pkg::DIM_MIN;
        end else if (int'(r_frame_width) > bbs_pkg::MAX_WIDTH) begin
            w_used = bbs_pkg::DIM_W'(bbs_pkg::MAX_WIDTH);
        end else begin
            w_used = r_frame_width;
        end
        if (r_frame_height < bbs_pkg::DIM_MIN) begin
            h_used = bbs_pkg::DIM_MIN;
        end else if (int'(r_frame_height) > bbs_pkg::MAX_HEIGHT) begin
            h_used = bbs_pkg::DIM_W'(bbs_pkg::MAX_HEIGHT);
        end else begin
            h_used = r_frame_height;
        end
    end

    assign w_m1     = w_used - 1'b1;
    assign h_m1     = h_used - 1'b1;
    assign col_last = bbs_pkg::CCMP_W'(r_in_col) >= bbs_pkg::CCMP_W'(w_m1);
    assign out_last = bbs_pkg::CCMP_W'(r_out_col) >= bbs_pkg::CCMP_W'(w_m1);
    assign row_last = bbs_pkg::RCMP_W'(r_in_row) >= bbs_pkg::RCMP_W'(h_m1);
    assign row_ge1  = (r_in_row != '0);
    assign row_is1  = (r_in_row == bbs_pkg::ROW_W'(1));
    assign col_prev = r_in_col - 1'b1;

    assign hm_edge = bbs_pkg::half2(r_px_newer, i_pix.pixel);
    assign hm_main = (r_in_col == bbs_pkg::COL_W'(1)) ? hm_edge :
                     bbs_pkg::div3(bbs_pkg::sum3(r_px_older, r_px_newer, i_pix.pixel));

    // output credit: words in the fifo plus the one in flight
    assign occupancy = (bbs_pkg::FIFO_AW+2)'(fifo_count) + (bbs_pkg::FIFO_AW+2)'(r_s1.valid);
    assign credit_ok = occupancy < (bbs_pkg::FIFO_AW+2)'(bbs_pkg::FIFO_DEPTH);

    assign i_pix.ready = !r_pend && credit_ok;
    assign in_acc      = i_pix.valid && i_pix.ready;
    assign is_flush    = (bbs_pkg::t_op'(i_pix.op) == bbs_pkg::OP_FLUSH);
    assign cfg_hit     = i_cfg_we && ((i_cfg_idx == bbs_pkg::REG_FRAME_WIDTH) ||
                                      (i_cfg_idx == bbs_pkg::REG_FRAME_HEIGHT));

    // issue: one line store access per cycle
    always_comb begin
        n_s1 = '0;
        if (r_pend && credit_ok) begin
            n_s1.valid         = 1'b1;
            n_s1.col           = r_pend_col;
            n_s1.hmean         = r_pend_hm;
            n_s1.emit          = r_pend_emit;
            n_s1.row_is_second = r_pend_is2;
            n_s1.eol           = 1'b1;
        end else if (in_acc && is_flush) begin
            n_s1.valid = 1'b1;
            n_s1.flush = 1'b1;
            n_s1.emit  = 1'b1;
            n_s1.col   = r_out_col;
            n_s1.eol   = out_last;
            n_s1.eof   = out_last;
        end else if (in_acc && (r_in_col != '0)) begin
            n_s1.valid         = 1'b1;
            n_s1.col           = col_prev;
            n_s1.hmean         = hm_main;
            n_s1.emit          = row_ge1;
            n_s1.row_is_second = row_is1;
            n_s1.eol           = bbs_pkg::CCMP_W'(col_prev) >= bbs_pkg::CCMP_W'(w_m1);
        end
        n_s1.fwd = n_s1.valid && r_s1.valid && !r_s1.flush && (r_s1.col == n_s1.col);
    end

    // second stage: combine with the stored rows, write back except on a flush
    assign line    = r_s1.fwd ? r_fwd_line : ram_q;
    assign two     = line[bbs_pkg::LINE_W-1:bbs_pkg::PIX_W];
    assign one     = line[bbs_pkg::PIX_W-1:0];
    assign wr_line = {one, r_s1.hmean};
    assign ram_we  = r_s1.valid && !r_s1.flush;

    always_comb begin
        res.eol = r_s1.eol;
        res.eof = r_s1.eof;
        if (r_s1.flush) begin
            res.blurred = bbs_pkg::half2(two, one);
        end else if (r_s1.row_is_second) begin
            res.blurred = bbs_pkg::half2(one, r_s1.hmean);
        end else begin
            res.blurred = bbs_pkg::div3(bbs_pkg::sum3(two, one, r_s1.hmean));
        end
    end

    assign res_push = r_s1.valid && r_s1.emit;

    bbs_line_ram u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1.col),
        .i_wdata (wr_line),
        .i_raddr (n_s1.col),
        .o_rdata (ram_q)
    );

    bbs_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_count (fifo_count),
        .o_res   (o_res)
    );

    always_ff @(posedge i_clk) begin
        r_fwd_line <= wr_line;
        if (in_acc && !is_flush) begin
            r_pend_col  <= r_in_col;
            r_pend_hm   <= hm_edge;
            r_pend_emit <= row_ge1;
            r_pend_is2  <= row_is1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bbs_pkg::FRAME_WIDTH_RST;
            r_frame_height <= bbs_pkg::FRAME_HEIGHT_RST;
            r_px_older     <= '0;
            r_px_newer     <= '0;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_pend         <= 1'b0;
            r_s1           <= '0;
        end else begin
            r_s1 <= n_s1;
            if (r_pend && credit_ok) begin
                r_pend <= 1'b0;
            end
            if (cfg_hit) begin
                if (i_cfg_idx == bbs_pkg::REG_FRAME_WIDTH) begin
                    r_frame_width <= i_cfg_data;
                end else begin
                    r_frame_height <= i_cfg_data;
                end
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
            end else if (in_acc && is_flush) begin
                r_out_col <= out_last ? '0 : r_out_col + 1'b1;
            end else if (in_acc) begin
                r_px_older <= r_px_newer;
                r_px_newer <= i_pix.pixel;
                if (col_last) begin
                    r_pend   <= 1'b1;
                    r_in_col <= '0;
                    if (row_last) begin
                        r_in_row  <= '0;
                        r_out_col <= '0;
                    end else begin
                        r_in_row <= r_in_row + 1'b1;
                    end
                end else begin
                    r_in_col <= r_in_col + 1'b1;
                end
            end
        end
    end

    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= (bbs_pkg::FIFO_AW+1)'(bbs_pkg::FIFO_DEPTH))
        else $error("result fifo overrun");

    a_line_end_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_flush && col_last && !cfg_hit) |=> (r_pend && !i_pix.ready))
        else $error("line end without second feed");

    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && r_s1.fwd) |-> $past(r_s1.valid && !r_s1.flush))
        else $error("forward without a preceding write");

    a_eof_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.end_of_frame) |-> o_res.end_of_line)
        else $error("end of frame without end of line");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import bbs_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 64;
    localparam int DIM_TOP       = (1 << DIM_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    class blur_track;
        logic [DIM_W-1:0] width_reg;
        logic [DIM_W-1:0] height_reg;
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
        logic [COL_W-1:0] in_col;
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] in_row;
        logic [PIX_W-1:0] two_back [MAX_WIDTH];
        logic [PIX_W-1:0] one_back [MAX_WIDTH];
        bit               two_ok [MAX_WIDTH];
        bit               one_ok [MAX_WIDTH];
        t_result          due_words [$];
        int               errors;

        function new();
            width_reg  = FRAME_WIDTH_RST;
            height_reg = FRAME_HEIGHT_RST;
            older      = '0;
            newer      = '0;
            in_col     = '0;
            out_col    = '0;
            in_row     = '0;
            errors     = 0;
        endfunction

        function int clip_dim(logic [DIM_W-1:0] v, int cap);
            if (v < DIM_MIN) return DIM_MIN;
            if (v > cap) return cap;
            return v;
        endfunction

        function int cols();
            return clip_dim(width_reg, MAX_WIDTH);
        endfunction

        function bit frame_last();
            return in_col >= cols() - 1 && in_row >= clip_dim(height_reg, MAX_HEIGHT) - 1;
        endfunction

        // a flush must only read line store entries that hold two rows
        function bit flush_ok();
            return two_ok[out_col] && one_ok[out_col];
        endfunction

        function logic [PIX_W-1:0] mean2(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
            return PIX_W'((int'(a) + int'(b)) / 2);
        endfunction

        function logic [PIX_W-1:0] mean3(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b,
                                         logic [PIX_W-1:0] c);
            return PIX_W'((int'(a) + int'(b) + int'(c)) / 3);
        endfunction

        function void queue_word(logic [PIX_W-1:0] v, logic eol, logic eof);
            t_result r;
            r.blurred = v;
            r.eol     = eol;
            r.eof     = eof;
            due_words.push_back(r);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            case (idx)
                REG_FRAME_WIDTH: width_reg = val;
                REG_FRAME_HEIGHT: height_reg = val;
                default: return;
            endcase
            in_col  = '0;
            in_row  = '0;
            out_col = '0;
        endfunction

        function void feed_column(int col, logic [PIX_W-1:0] hm, int w);
            if (in_row >= 1) begin
                queue_word((in_row == 1) ? mean2(one_back[col], hm)
                                         : mean3(two_back[col], one_back[col], hm),
                           col >= w - 1, 1'b0);
            end
            two_back[col] = one_back[col];
            two_ok[col]   = one_ok[col];
            one_back[col] = hm;
            one_ok[col]   = 1'b1;
        endfunction

        function void take_word(t_op op, logic [PIX_W-1:0] px);
            int w;
            int h;
            bit last;
            w = cols();
            h = clip_dim(height_reg, MAX_HEIGHT);
            if (op == OP_FLUSH) begin
                last = out_col >= w - 1;
                queue_word(mean2(two_back[out_col], one_back[out_col]), last, last);
                out_col = last ? '0 : out_col + 1'b1;
                return;
            end
            if (in_col >= 1)
                feed_column(in_col - 1, (in_col == 1) ? mean2(newer, px)
                                                      : mean3(older, newer, px), w);
            if (in_col >= w - 1)
                feed_column(in_col, mean2(newer, px), w);
            older = newer;
            newer = px;
            if (in_col >= w - 1) begin
                in_col = '0;
                if (in_row >= h - 1) begin
                    in_row  = '0;
                    out_col = '0;
                end else begin
                    in_row++;
                end
            end else begin
                in_col++;
            end
        endfunction

        function void check_word(logic [PIX_W-1:0] blurred, logic eol, logic eof);
            t_result want;
            if (due_words.size() == 0) begin
                $error("unexpected word: blurred %0d end_of_line %0b end_of_frame %0b",
                       blurred, eol, eof);
                errors++;
                return;
            end
            want = due_words.pop_front();
            if (blurred !== want.blurred) begin
                $error("blurred: expected %0d, got %0d", want.blurred, blurred);
                errors++;
            end
            if (eol !== want.eol) begin
                $error("end_of_line: expected %0b, got %0b", want.eol, eol);
                errors++;
            end
            if (eof !== want.eof) begin
                $error("end_of_frame: expected %0b, got %0b", want.eof, eof);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DIM_W-1:0]     cfg_data;

    int gap_pct   = 0;
    int stall_pct = 0;
    int hold_asks = 0;
    int holds_done = 0;

    blur_track blur = new();

    bbs_in_if  pix_if ();
    bbs_out_if res_if ();

    box_blur_3x3_separable dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (pix_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #(6_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (holds_done != hold_asks) begin
                holds_done = hold_asks;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                res_if.ready <= 1'b1;
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready)
            blur.check_word(res_if.blurred, res_if.end_of_line, res_if.end_of_frame);
    end

    function automatic logic [DIM_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return DIM_W'($urandom_range(0, 1));
            1: return DIM_W'($urandom_range(13, 40));
            default: return DIM_W'($urandom_range(2, 12));
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_height();
        case ($urandom_range(0, 9))
            0: return DIM_W'($urandom_range(0, 1));
            1: return DIM_W'($urandom_range(MAX_HEIGHT + 1, DIM_TOP));
            default: return DIM_W'($urandom_range(2, 6));
        endcase
    endfunction

    task automatic put_word(t_op op, logic [PIX_W-1:0] px);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.op    <= op;
        pix_if.pixel <= px;
        do @(posedge clk); while (!pix_if.ready);
        blur.take_word(op, px);
    endtask

    task automatic settle();
        pix_if.valid <= 1'b0;
        while (blur.due_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        blur.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly whole frames followed by a row of flushes; the odd stray flush when noisy
    task automatic run_items(int len, bit noisy);
        int flush_due;
        bit ends;
        flush_due = 0;
        repeat (len) begin
            if (flush_due > 0) begin
                put_word(OP_FLUSH, PIX_W'($urandom));
                flush_due--;
            end else if (noisy && $urandom_range(0, 15) == 0 && blur.flush_ok()) begin
                put_word(OP_FLUSH, PIX_W'($urandom));
            end else begin
                ends = blur.frame_last();
                put_word(OP_PIXEL, ($urandom_range(0, 3) == 0)
                                   ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                   : PIX_W'($urandom_range(0, 255)));
                if (ends)
                    flush_due = blur.cols();
            end
        end
    endtask

    initial begin
        int small_items;
        int len;
        int phase;
        int pcts [3];
        logic [PIX_W-1:0] sweep [9];

        pcts  = '{0, 10, 30};
        sweep = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        rst_n        <= 1'b0;
        pix_if.valid <= 1'b0;
        pix_if.op    <= OP_PIXEL;
        pix_if.pixel <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= REG_FRAME_WIDTH;
        cfg_data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_reg(REG_FRAME_WIDTH, 10'd3);
        set_reg(REG_FRAME_HEIGHT, 10'd3);
        foreach (sweep[i])
            put_word(OP_PIXEL, sweep[i]);
        repeat (4) put_word(OP_FLUSH, 8'hA5);
        put_word(OP_PIXEL, 8'h00);
        put_word(OP_PIXEL, 8'hFF);
        put_word(OP_PIXEL, 8'h00);
        put_word(OP_PIXEL, 8'hFF);
        // unmapped index mid-frame: the frame must carry on
        settle();
        set_reg(REG_SPARE_A, DIM_W'(DIM_TOP));
        put_word(OP_PIXEL, 8'h00);
        put_word(OP_FLUSH, 8'h5A);
        put_word(OP_PIXEL, 8'hFF);

        phase = 0;
        small_items = 0;
        while (small_items < 400) begin
            settle();
            case ($urandom_range(0, 5))
                0: set_reg(REG_FRAME_WIDTH, pick_width());
                1: set_reg(REG_FRAME_HEIGHT, pick_height());
                2: set_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                           DIM_W'($urandom));
                default: begin
                    set_reg(REG_FRAME_WIDTH, pick_width());
                    set_reg(REG_FRAME_HEIGHT, pick_height());
                end
            endcase
            gap_pct   = pcts[$urandom_range(0, 2)];
            stall_pct = pcts[$urandom_range(0, 2)];
            if (phase == 1) begin
                gap_pct = 0;
                hold_asks++;
            end
            len = $urandom_range(30, 150);
            run_items(len, 1'b1);
            small_items += len;
            phase++;
        end

        settle();
        gap_pct   = 0;
        stall_pct = 0;
        if ($urandom_range(0, 1)) begin
            set_reg(REG_FRAME_WIDTH, $urandom_range(0, 1) ? DIM_W'(MAX_WIDTH)
                                     : DIM_W'($urandom_range(MAX_WIDTH + 1, DIM_TOP)));
            set_reg(REG_FRAME_HEIGHT, DIM_W'($urandom_range(0, 2)));
            run_items(2 * MAX_WIDTH, 1'b0);
        end else begin
            set_reg(REG_FRAME_WIDTH, DIM_W'($urandom_range(0, 2)));
            set_reg(REG_FRAME_HEIGHT, $urandom_range(0, 1) ? DIM_W'(MAX_HEIGHT)
                                      : DIM_W'($urandom_range(MAX_HEIGHT + 1, DIM_TOP)));
            run_items(2 * MAX_HEIGHT + 2, 1'b0);
        end

        settle();
        if (blur.errors == 0 && blur.due_words.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
